>>> hw/rtl/lrs_pkg.sv
// Shared types, constants and a helper function for the link recovery supervisor.
package lrs_pkg;

   localparam int unsigned CountWidth = 8;
   localparam int unsigned TimeWidth  = 32;
   localparam int unsigned CsrIndexWidth = 3;

   localparam logic [CountWidth-1:0] CountMax = '1;

   localparam logic [CountWidth-1:0] BounceAfterReset   = 8'd5;
   localparam logic [CountWidth-1:0] RestartAfterReset  = 8'd10;
   localparam logic [CountWidth-1:0] PingFailLimitReset = 8'd6;
   localparam logic [TimeWidth-1:0]  StaleMsReset       = 32'd900000;
   localparam logic [TimeWidth-1:0]  AnnounceMsReset    = 32'd600000;
   localparam logic [TimeWidth-1:0]  MemoryFloorReset   = 32'd4000;
   localparam logic [TimeWidth-1:0]  MemoryHoldMsReset  = 32'd60000;

   typedef enum logic [1:0] {
      ACTION_NONE      = 2'd0,
      ACTION_RECONNECT = 2'd1,
      ACTION_BOUNCE    = 2'd2,
      ACTION_RESTART   = 2'd3
   } action_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_BOUNCE_AFTER    = 3'd0,
      CSR_RESTART_AFTER   = 3'd1,
      CSR_PING_FAIL_LIMIT = 3'd2,
      CSR_STALE_MS        = 3'd3,
      CSR_ANNOUNCE_MS     = 3'd4,
      CSR_MEMORY_FLOOR    = 3'd5,
      CSR_MEMORY_HOLD_MS  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [TimeWidth-1:0] now_ms;
      logic                 link_up;
      logic                 has_credentials;
      logic [TimeWidth-1:0] ping_ok_total;
      logic [TimeWidth-1:0] ping_fail_total;
      logic [TimeWidth-1:0] http_total;
      logic [TimeWidth-1:0] address_time_ms;
      logic [TimeWidth-1:0] free_memory;
   } req_type;

   typedef struct packed {
      logic [1:0] action;
      logic       resume_advertising;
      logic       announce;
      logic       memory_alarm;
   } rsp_type;

   typedef struct packed {
      logic [CountWidth-1:0] bounce_after;
      logic [CountWidth-1:0] restart_after;
      logic [CountWidth-1:0] ping_fail_limit;
      logic [TimeWidth-1:0]  stale_ms;
      logic [TimeWidth-1:0]  announce_ms;
      logic [TimeWidth-1:0]  memory_floor;
      logic [TimeWidth-1:0]  memory_hold_ms;
   } cfg_type;

   function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] value);
      sat_inc = (value == CountMax) ? CountMax : value + 1'b1;
   endfunction

endpackage

>>> hw/rtl/lrs_if.sv
// Handshake interfaces for the request, response and register write channels.
interface lrs_req_if;
   logic             valid;
   logic             ready;
   lrs_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface lrs_rsp_if;
   logic             valid;
   logic             ready;
   lrs_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface lrs_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [lrs_pkg::CsrIndexWidth-1:0]     index;
   logic [lrs_pkg::TimeWidth-1:0]         data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/lrs_csr.sv
// Configuration register file with reset values and indexed writes.
module lrs_csr (
   input  logic             clock,
   input  logic             reset,
   lrs_csr_if.sink          csr_chan,
   output lrs_pkg::cfg_type cfg
);

   lrs_pkg::cfg_type cfg_ff;
   lrs_pkg::cfg_type cfg_in;

   assign csr_chan.ready = !reset;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (lrs_pkg::csr_index_type'(csr_chan.index))
            lrs_pkg::CSR_BOUNCE_AFTER:
               cfg_in.bounce_after = csr_chan.data[lrs_pkg::CountWidth-1:0];
            lrs_pkg::CSR_RESTART_AFTER:
               cfg_in.restart_after = csr_chan.data[lrs_pkg::CountWidth-1:0];
            lrs_pkg::CSR_PING_FAIL_LIMIT:
               cfg_in.ping_fail_limit = csr_chan.data[lrs_pkg::CountWidth-1:0];
            lrs_pkg::CSR_STALE_MS:       cfg_in.stale_ms = csr_chan.data;
            lrs_pkg::CSR_ANNOUNCE_MS:    cfg_in.announce_ms = csr_chan.data;
            lrs_pkg::CSR_MEMORY_FLOOR:   cfg_in.memory_floor = csr_chan.data;
            lrs_pkg::CSR_MEMORY_HOLD_MS: cfg_in.memory_hold_ms = csr_chan.data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bounce_after    <= lrs_pkg::BounceAfterReset;
         cfg_ff.restart_after   <= lrs_pkg::RestartAfterReset;
         cfg_ff.ping_fail_limit <= lrs_pkg::PingFailLimitReset;
         cfg_ff.stale_ms        <= lrs_pkg::StaleMsReset;
         cfg_ff.announce_ms     <= lrs_pkg::AnnounceMsReset;
         cfg_ff.memory_floor    <= lrs_pkg::MemoryFloorReset;
         cfg_ff.memory_hold_ms  <= lrs_pkg::MemoryHoldMsReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hw/rtl/lrs_step.sv
// Supervisor state registers and the single-pass decision logic for one tick.
module lrs_step (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  lrs_pkg::cfg_type cfg,
   input  lrs_pkg::req_type req,
   output lrs_pkg::rsp_type rsp
);

   logic [lrs_pkg::CountWidth-1:0] streak_ff, streak_in;
   logic [lrs_pkg::CountWidth-1:0] run_ff, run_in;
   logic [lrs_pkg::TimeWidth-1:0]  ok_snap_ff, ok_snap_in;
   logic [lrs_pkg::TimeWidth-1:0]  fail_snap_ff, fail_snap_in;
   logic [lrs_pkg::TimeWidth-1:0]  http_snap_ff, http_snap_in;
   logic [lrs_pkg::TimeWidth-1:0]  last_ann_ff, last_ann_in;
   logic [lrs_pkg::TimeWidth-1:0]  low_since_ff, low_since_in;

   logic [lrs_pkg::CountWidth-1:0] streak_inc;
   logic [lrs_pkg::CountWidth-1:0] run_next;
   logic [lrs_pkg::TimeWidth-1:0]  ann_base;
   logic                           stale_idle;

   always_comb begin
      streak_in    = streak_ff;
      run_in       = run_ff;
      ok_snap_in   = ok_snap_ff;
      fail_snap_in = fail_snap_ff;
      http_snap_in = http_snap_ff;
      last_ann_in  = last_ann_ff;
      low_since_in = low_since_ff;
      rsp          = '0;

      streak_inc = lrs_pkg::sat_inc(streak_ff);
      if (req.ping_ok_total > ok_snap_ff) begin
         run_next = '0;
      end else if (req.ping_fail_total > fail_snap_ff) begin
         run_next = lrs_pkg::sat_inc(run_ff);
      end else begin
         run_next = run_ff;
      end
      stale_idle = (req.address_time_ms != '0)
                   && ((req.now_ms - req.address_time_ms) > cfg.stale_ms)
                   && (req.http_total == http_snap_ff) && (run_next != '0);
      ann_base = (last_ann_ff == '0) ? req.now_ms : last_ann_ff;

      if (!req.link_up) begin
         if (!req.has_credentials) begin
            streak_in = '0;
         end else if (streak_inc >= cfg.restart_after) begin
            rsp.action   = lrs_pkg::ACTION_RESTART;
            streak_in    = '0;
            run_in       = '0;
            ok_snap_in   = '0;
            fail_snap_in = '0;
            http_snap_in = '0;
            last_ann_in  = '0;
            low_since_in = '0;
         end else begin
            streak_in  = streak_inc;
            run_in     = '0;
            rsp.action = (streak_inc >= cfg.bounce_after) ? lrs_pkg::ACTION_BOUNCE
                                                          : lrs_pkg::ACTION_RECONNECT;
         end
      end else begin
         rsp.resume_advertising = (streak_ff != '0);
         streak_in    = '0;
         ok_snap_in   = req.ping_ok_total;
         fail_snap_in = req.ping_fail_total;
         if (run_next >= cfg.ping_fail_limit) begin
            rsp.action = lrs_pkg::ACTION_RECONNECT;
            run_in     = '0;
         end else begin
            run_in       = run_next;
            http_snap_in = req.http_total;
            if (stale_idle) begin
               rsp.action = lrs_pkg::ACTION_RECONNECT;
            end else begin
               if ((req.now_ms - ann_base) > cfg.announce_ms) begin
                  rsp.announce = 1'b1;
                  last_ann_in  = req.now_ms;
               end else begin
                  last_ann_in = ann_base;
               end
               if (req.free_memory < cfg.memory_floor) begin
                  if (low_since_ff == '0) begin
                     low_since_in = req.now_ms;
                  end else if ((req.now_ms - low_since_ff) > cfg.memory_hold_ms) begin
                     rsp.memory_alarm = 1'b1;
                     low_since_in     = req.now_ms;
                  end
               end else begin
                  low_since_in = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         streak_ff    <= '0;
         run_ff       <= '0;
         ok_snap_ff   <= '0;
         fail_snap_ff <= '0;
         http_snap_ff <= '0;
         last_ann_ff  <= '0;
         low_since_ff <= '0;
      end else if (enable) begin
         streak_ff    <= streak_in;
         run_ff       <= run_in;
         ok_snap_ff   <= ok_snap_in;
         fail_snap_ff <= fail_snap_in;
         http_snap_ff <= http_snap_in;
         last_ann_ff  <= last_ann_in;
         low_since_ff <= low_since_in;
      end
   end

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      enable && rsp.action == lrs_pkg::ACTION_RESTART
      |=> streak_ff == '0 && run_ff == '0 && last_ann_ff == '0 && low_since_ff == '0)
      else $error("restart did not clear supervisor state");

   a_pulse_quiet: assert property (@(posedge clock) disable iff (reset)
      enable && (rsp.announce || rsp.memory_alarm) |-> rsp.action == lrs_pkg::ACTION_NONE)
      else $error("pulse raised together with a recovery action");

   a_streak_link: assert property (@(posedge clock) disable iff (reset)
      enable && req.link_up |=> streak_ff == '0)
      else $error("failure streak survived a link-up tick");

endmodule

>>> hw/rtl/link_recovery_supervisor.sv
// Top level of the link recovery supervisor: request register, step logic, response register.
//
//   Channel  Direction  Carries
//   req      in         one health tick per request
//   rsp      out        action, resume, announce and alarm flags per request
//   csr      in         register index and write data
//
// Each request is held in the request register and decided there, then waits
// in the response register until it is taken.
// A new request is accepted every cycle while responses keep flowing.
// A response becomes valid when its decided request is written into the response register.
// Reset is synchronous and active high; it restores register defaults and clears the supervisor state and valid flags.
// A stalled response holds the request register, which then stalls the input side.
module link_recovery_supervisor (
   input  logic     clock,
   input  logic     reset,
   lrs_req_if.sink  req_chan,
   lrs_rsp_if.source rsp_chan,
   lrs_csr_if.sink  csr_chan
);

   lrs_pkg::cfg_type cfg;
   lrs_pkg::req_type s1_data_ff;
   logic             s1_valid_ff, s1_valid_in;
   lrs_pkg::rsp_type step_rsp;
   lrs_pkg::rsp_type out_data_ff;
   logic             out_valid_ff, out_valid_in;
   logic             advance;
   logic             take;

   assign advance        = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !reset && (!s1_valid_ff || advance);
   assign take           = req_chan.valid && req_chan.ready;
   assign s1_valid_in    = take || (s1_valid_ff && !advance);
   assign out_valid_in   = advance || (out_valid_ff && !rsp_chan.ready);

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_data_ff;

   lrs_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   lrs_step u_step (
      .clock  (clock),
      .reset  (reset),
      .enable (advance),
      .cfg    (cfg),
      .req    (s1_data_ff),
      .rsp    (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_data_ff <= req_chan.data;
      end
      if (advance) begin
         out_data_ff <= step_rsp;
      end
   end

   a_ready_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> s1_valid_ff && out_valid_ff && !rsp_chan.ready)
      else $error("request side stalled without a blocked response");

   a_out_drains: assert property (@(posedge clock) disable iff (reset)
      $fell(out_valid_ff) |-> $past(rsp_chan.ready))
      else $error("response dropped without being taken");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("decided request did not reach the response register");

endmodule

>>> tb/tb_link_recovery_supervisor.sv
// Self-checking testbench for the link recovery supervisor with a built-in health tick predictor.
`timescale 1ns / 100ps

class recovery_scoreboard;
   lrs_pkg::cfg_type cfg;
   logic [7:0]       streak;
   logic [7:0]       ping_run;
   logic [31:0]      ok_seen;
   logic [31:0]      fail_seen;
   logic [31:0]      http_seen;
   logic [31:0]      announced_at;
   logic [31:0]      low_since;
   lrs_pkg::rsp_type due_responses[$];
   int unsigned      mismatches;

   function new();
      cfg.bounce_after    = lrs_pkg::BounceAfterReset;
      cfg.restart_after   = lrs_pkg::RestartAfterReset;
      cfg.ping_fail_limit = lrs_pkg::PingFailLimitReset;
      cfg.stale_ms        = lrs_pkg::StaleMsReset;
      cfg.announce_ms     = lrs_pkg::AnnounceMsReset;
      cfg.memory_floor    = lrs_pkg::MemoryFloorReset;
      cfg.memory_hold_ms  = lrs_pkg::MemoryHoldMsReset;
      mismatches = 0;
      clear_history();
   endfunction

   function void clear_history();
      streak       = '0;
      ping_run     = '0;
      ok_seen      = '0;
      fail_seen    = '0;
      http_seen    = '0;
      announced_at = '0;
      low_since    = '0;
   endfunction

   function logic [7:0] bump(logic [7:0] count);
      return (count == 8'hFF) ? count : count + 8'd1;
   endfunction

   function void write_register(logic [2:0] idx, logic [31:0] value);
      case (idx)
         lrs_pkg::CSR_BOUNCE_AFTER:    cfg.bounce_after    = value[7:0];
         lrs_pkg::CSR_RESTART_AFTER:   cfg.restart_after   = value[7:0];
         lrs_pkg::CSR_PING_FAIL_LIMIT: cfg.ping_fail_limit = value[7:0];
         lrs_pkg::CSR_STALE_MS:        cfg.stale_ms        = value;
         lrs_pkg::CSR_ANNOUNCE_MS:     cfg.announce_ms     = value;
         lrs_pkg::CSR_MEMORY_FLOOR:    cfg.memory_floor    = value;
         lrs_pkg::CSR_MEMORY_HOLD_MS:  cfg.memory_hold_ms  = value;
         default: ;
      endcase
   endfunction

   function lrs_pkg::rsp_type decide(lrs_pkg::req_type t);
      lrs_pkg::rsp_type r;
      logic [31:0]      age;
      r = '0;
      if (!t.link_up) begin
         if (!t.has_credentials) begin
            streak = '0;
         end else begin
            streak = bump(streak);
            if (streak >= cfg.restart_after) begin
               r.action = lrs_pkg::ACTION_RESTART;
               clear_history();
            end else begin
               r.action = (streak >= cfg.bounce_after) ? lrs_pkg::ACTION_BOUNCE
                                                       : lrs_pkg::ACTION_RECONNECT;
               ping_run = '0;
            end
         end
         return r;
      end

      r.resume_advertising = (streak != 8'd0);
      streak = '0;

      // Activity is seen by a plain greater-than against the last counter values.
      if (t.ping_ok_total > ok_seen) begin
         ping_run = '0;
      end else if (t.ping_fail_total > fail_seen) begin
         ping_run = bump(ping_run);
      end
      ok_seen   = t.ping_ok_total;
      fail_seen = t.ping_fail_total;

      if (ping_run >= cfg.ping_fail_limit) begin
         r.action = lrs_pkg::ACTION_RECONNECT;
         ping_run = '0;
         return r;
      end

      age = t.now_ms - t.address_time_ms;
      if (t.address_time_ms != 32'd0 && age > cfg.stale_ms && t.http_total == http_seen &&
          ping_run != 8'd0) begin
         r.action  = lrs_pkg::ACTION_RECONNECT;
         http_seen = t.http_total;
         return r;
      end
      http_seen = t.http_total;

      if (announced_at == 32'd0) begin
         announced_at = t.now_ms;
      end
      age = t.now_ms - announced_at;
      if (age > cfg.announce_ms) begin
         r.announce   = 1'b1;
         announced_at = t.now_ms;
      end

      if (t.free_memory < cfg.memory_floor) begin
         if (low_since == 32'd0) begin
            low_since = t.now_ms;
         end else begin
            age = t.now_ms - low_since;
            if (age > cfg.memory_hold_ms) begin
               r.memory_alarm = 1'b1;
               low_since      = t.now_ms;
            end
         end
      end else begin
         low_since = '0;
      end
      return r;
   endfunction

   function void note_tick(lrs_pkg::req_type t);
      due_responses.push_back(decide(t));
   endfunction

   function void compare_field(string field, logic [1:0] want, logic [1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatches++;
      end
   endfunction

   function void check_response(lrs_pkg::rsp_type got);
      lrs_pkg::rsp_type want;
      if (due_responses.size() == 0) begin
         $display("%0t: response with none expected, actual %h", $time, got);
         mismatches++;
         return;
      end
      want = due_responses.pop_front();
      compare_field("action", want.action, got.action);
      compare_field("resume_advertising", 2'(want.resume_advertising),
                    2'(got.resume_advertising));
      compare_field("announce", 2'(want.announce), 2'(got.announce));
      compare_field("memory_alarm", 2'(want.memory_alarm), 2'(got.memory_alarm));
   endfunction

   function bit drained();
      return due_responses.size() == 0;
   endfunction
endclass

module tb_link_recovery_supervisor;

   localparam int unsigned StallLimit = 2000;
   localparam logic [lrs_pkg::CsrIndexWidth-1:0] CsrNoRegister = 3'd7;

   logic clock = 1'b0;
   logic reset;

   lrs_req_if req_bus ();
   lrs_rsp_if rsp_bus ();
   lrs_csr_if csr_bus ();

   link_recovery_supervisor uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   recovery_scoreboard sb;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned quiet_cycles;
   int unsigned step_max;
   logic [31:0] sim_now;
   logic [31:0] ok_count;
   logic [31:0] fail_count;
   logic [31:0] http_count;
   logic [31:0] addr_stamp;
   logic        link_state;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            sb.check_response(rsp_bus.data);
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < StallLimit) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("FAILURE");
      $finish;
   end

   task automatic send_request(input lrs_pkg::req_type t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data  <= t;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_tick(t);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [31:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      sb.write_register(idx, value);
   endtask

   task automatic configure(input logic [7:0] bounce, input logic [7:0] restart,
                            input logic [7:0] limit, input logic [31:0] stale,
                            input logic [31:0] announce_gap, input logic [31:0] floor,
                            input logic [31:0] hold);
      logic [23:0] junk;
      junk = 24'($urandom);
      write_csr(lrs_pkg::CSR_BOUNCE_AFTER, {junk, bounce});
      write_csr(lrs_pkg::CSR_RESTART_AFTER, {~junk, restart});
      write_csr(lrs_pkg::CSR_PING_FAIL_LIMIT, {junk, limit});
      write_csr(lrs_pkg::CSR_STALE_MS, stale);
      write_csr(lrs_pkg::CSR_ANNOUNCE_MS, announce_gap);
      write_csr(lrs_pkg::CSR_MEMORY_FLOOR, floor);
      write_csr(lrs_pkg::CSR_MEMORY_HOLD_MS, hold);
      write_csr(CsrNoRegister, $urandom);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (!sb.drained()) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic lrs_pkg::req_type tick(input logic [31:0] now, input logic link,
                                             input logic creds, input logic [31:0] ok,
                                             input logic [31:0] fail,
                                             input logic [31:0] http,
                                             input logic [31:0] addr,
                                             input logic [31:0] mem);
      lrs_pkg::req_type t;
      t.now_ms          = now;
      t.link_up         = link;
      t.has_credentials = creds;
      t.ping_ok_total   = ok;
      t.ping_fail_total = fail;
      t.http_total      = http;
      t.address_time_ms = addr;
      t.free_memory     = mem;
      return t;
   endfunction

   function automatic lrs_pkg::req_type next_tick();
      lrs_pkg::req_type t;
      logic [31:0]      floor;
      int unsigned      roll;
      floor = sb.cfg.memory_floor;
      roll  = $urandom_range(99);
      if (roll < 8) begin
         return tick($urandom, $urandom_range(1) != 0, $urandom_range(1) != 0, $urandom,
                     $urandom, $urandom, $urandom, $urandom);
      end

      roll = $urandom_range(99);
      if (roll < 3) begin
         sim_now = '0;
      end else if (roll < 5) begin
         sim_now = sim_now + $urandom;
      end else begin
         sim_now = sim_now + $urandom_range(step_max);
      end

      if ($urandom_range(99) < 12) begin
         link_state = !link_state;
         if (link_state) begin
            addr_stamp = sim_now;
         end
      end
      if ($urandom_range(99) < 4) begin
         addr_stamp = '0;
      end

      roll = $urandom_range(99);
      if (roll < 35) begin
         ok_count = ok_count + $urandom_range(3, 1);
      end else if (roll < 80) begin
         fail_count = fail_count + $urandom_range(3, 1);
      end else if (roll < 83) begin
         ok_count   = $urandom_range(7);
         fail_count = $urandom_range(7);
      end
      if ($urandom_range(99) < 25) begin
         http_count = http_count + 32'd1;
      end

      t = tick(sim_now, link_state, $urandom_range(99) < 90, ok_count, fail_count, http_count,
               addr_stamp, '0);
      roll = $urandom_range(99);
      if (roll < 40 && floor != 32'd0) begin
         t.free_memory = $urandom % floor;
      end else if (roll < 95) begin
         t.free_memory = floor + $urandom_range(5000);
      end else begin
         t.free_memory = $urandom;
      end
      return t;
   endfunction

   initial begin
      sb = new();
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.data  <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= '0;
      csr_bus.data  <= '0;
      sim_now    = '0;
      ok_count   = '0;
      fail_count = '0;
      http_count = '0;
      addr_stamp = '0;
      link_state = 1'b1;
      step_max   = 2000;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset values first, then small thresholds so every path is reached in a few ticks.
      send_request(tick(32'd0, 1'b1, 1'b1, '0, '0, '0, '0, '1));
      send_request(tick(32'd10, 1'b0, 1'b0, '0, '0, '0, '0, '1));
      settle();
      configure(8'd2, 8'd3, 8'd2, 32'd100, 32'd50, 32'd1000, 32'd20);
      send_request(tick(32'd0, 1'b1, 1'b1, '0, '0, '0, '0, '1));
      send_request(tick(32'd10, 1'b0, 1'b0, '0, '0, '0, '0, '1));
      send_request(tick(32'd20, 1'b0, 1'b1, '0, '0, '0, '0, '1));
      send_request(tick(32'd30, 1'b0, 1'b1, '0, '0, '0, '0, '1));
      send_request(tick(32'd40, 1'b0, 1'b1, '0, '0, '0, '0, '1));
      send_request(tick(32'd50, 1'b0, 1'b1, '0, '0, '0, '0, '1));
      send_request(tick(32'd60, 1'b1, 1'b1, '0, '0, '0, 32'd60, 32'd5000));
      send_request(tick(32'd70, 1'b1, 1'b1, '0, 32'd1, '0, 32'd60, 32'd5000));
      send_request(tick(32'd80, 1'b1, 1'b1, '0, 32'd2, '0, 32'd60, 32'd5000));
      send_request(tick(32'd90, 1'b1, 1'b1, 32'd5, 32'd2, '0, 32'd60, 32'd5000));
      send_request(tick(32'd300, 1'b1, 1'b1, 32'd5, 32'd3, '0, 32'd60, 32'd5000));
      send_request(tick(32'd400, 1'b1, 1'b1, 32'd6, 32'd3, 32'd1, 32'd60, 32'd5000));
      send_request(tick(32'd410, 1'b1, 1'b1, 32'd7, 32'd3, 32'd2, 32'd60, 32'd10));
      send_request(tick(32'd440, 1'b1, 1'b1, 32'd8, 32'd3, 32'd3, 32'd60, 32'd10));
      send_request(tick('1, 1'b1, 1'b1, '1, '1, '1, '1, '0));
      send_request(tick(32'd5, 1'b1, 1'b1, '0, '0, '0, 32'd1, '1));
      send_request(tick(32'd0, 1'b1, 1'b1, '0, 32'd1, '0, 32'd1, '0));
      send_request(tick('1, 1'b0, 1'b1, '1, '1, '1, '1, '1));
      send_request(tick(32'd0, 1'b0, 1'b0, '0, '0, '0, '0, '0));
      send_request(tick(32'd1, 1'b1, 1'b0, '0, '0, '0, '0, '0));

      for (int p = 0; p < 8; p++) begin
         settle();
         case (p % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 73;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 73;
            end
            default: begin
               send_idle_pct  = 29;
               recv_stall_pct = 29;
            end
         endcase
         step_max = 3000;
         case (p)
            0: configure(8'd5, 8'd10, 8'd6, 32'd9000, 32'd6000, 32'd4000, 32'd3000);
            4: configure('0, '0, '0, '0, '0, '0, '0);
            5: configure('1, '1, '1, '1, '1, '1, '1);
            6: begin
               step_max = 32'h3FFF_FFFF;
               configure(8'($urandom), 8'($urandom), 8'($urandom), $urandom, $urandom,
                         $urandom, $urandom);
            end
            default: configure(8'($urandom_range(12, 1)), 8'($urandom_range(20, 1)),
                               8'($urandom_range(10, 1)), $urandom_range(20000),
                               $urandom_range(20000), $urandom_range(100000, 1000),
                               $urandom_range(20000));
         endcase
         for (int i = 0; i < 250; i++) begin
            if (p == 3 && i == 125) begin
               settle();
            end
            send_request(next_tick());
         end
      end

      settle();
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.drained()) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

>>> filelist.f
hw/rtl/lrs_pkg.sv
hw/rtl/lrs_if.sv
hw/rtl/lrs_csr.sv
hw/rtl/lrs_step.sv
hw/rtl/link_recovery_supervisor.sv
tb/tb_link_recovery_supervisor.sv
